// ----- rtl/cc20_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cc20_pkg
// Shared types and constants for the ChaCha20 keystream generator.
// ----------------------------------------------------------------------------
package cc20_pkg;

	localparam int BLOCK_BYTES = 64;
	localparam int STATE_WORDS = 16;
	localparam int CNT_W       = 7;
	localparam int CFG_W       = 64;
	localparam int CFG_IDX_W   = 3;

	localparam logic [CNT_W-1:0] MAX_COUNT = CNT_W'(BLOCK_BYTES);

	typedef logic [31:0] word_t;

	localparam word_t SIGMA_0 = 32'h6170_7865;
	localparam word_t SIGMA_1 = 32'h3320_646e;
	localparam word_t SIGMA_2 = 32'h7962_2d32;
	localparam word_t SIGMA_3 = 32'h6b20_6574;

	localparam logic [CFG_IDX_W-1:0] REG_KEY_0 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_1 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_2 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_3 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_NONCE = 3'd4;

	localparam logic [1:0] STEP_LAST = 2'd3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ERR,
		ST_EMIT,
		ST_LOAD,
		ST_ROUND,
		ST_ADD
	} cc20_state_t;

	typedef struct packed {
		logic       load_init;
		logic       round_en;
		logic [1:0] step;
		logic       diag;
		logic       add_back;
		logic       emit;
		logic       emit_last;
		logic       emit_err;
	} cc20_cmd_t;

	typedef struct packed {
		logic buf_empty;
		logic out_ready;
	} cc20_sts_t;

endpackage

// ----- rtl/cc20_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cc20_datapath
// Key/nonce registers, block counter, ChaCha state with a quarter-round step
// unit, read position and the output register.
// ----------------------------------------------------------------------------
module cc20_datapath
	import cc20_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  cc20_cmd_t            cmd,
	output cc20_sts_t            sts,
	input  logic                 out_stall,
	output logic                 out_valid,
	output logic [7:0]           key_byte,
	output logic                 last_byte,
	output logic                 status
);

	logic [CFG_W-1:0] key0_q, key1_q, key2_q, key3_q, nonce_q;
	logic [63:0]      ctr_q;
	logic [CNT_W-1:0] pos_q;
	word_t            w_q   [STATE_WORDS];
	word_t            init  [STATE_WORDS];
	word_t            stp   [STATE_WORDS];
	word_t            rot   [STATE_WORDS];
	logic             cfg_hit;
	logic             out_valid_q;
	logic [7:0]       key_byte_q;
	logic             last_q;
	logic             status_q;
	logic [7:0]       cur_byte;

	always_comb begin
		unique case (cfg_index)
			REG_KEY_0, REG_KEY_1, REG_KEY_2, REG_KEY_3, REG_NONCE: cfg_hit = cfg_we;
			default: cfg_hit = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key0_q  <= '0;
			key1_q  <= '0;
			key2_q  <= '0;
			key3_q  <= '0;
			nonce_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_KEY_0: key0_q  <= cfg_data;
				REG_KEY_1: key1_q  <= cfg_data;
				REG_KEY_2: key2_q  <= cfg_data;
				REG_KEY_3: key3_q  <= cfg_data;
				REG_NONCE: nonce_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		init[0]  = SIGMA_0;
		init[1]  = SIGMA_1;
		init[2]  = SIGMA_2;
		init[3]  = SIGMA_3;
		init[4]  = key0_q[31:0];
		init[5]  = key0_q[63:32];
		init[6]  = key1_q[31:0];
		init[7]  = key1_q[63:32];
		init[8]  = key2_q[31:0];
		init[9]  = key2_q[63:32];
		init[10] = key3_q[31:0];
		init[11] = key3_q[63:32];
		init[12] = ctr_q[31:0];
		init[13] = ctr_q[63:32];
		init[14] = nonce_q[31:0];
		init[15] = nonce_q[63:32];
	end

	// one quarter-round step on all four columns; rows 1..3 are rotated after
	// the last step so that diagonal rounds run as column rounds, and rotated back after a diagonal round
	always_comb begin
		word_t t;
		stp = w_q;
		for (int i = 0; i < 4; i++) begin
			case (cmd.step)
				2'd0: begin
					t          = w_q[i] + w_q[4+i];
					stp[i]     = t;
					t          = w_q[12+i] ^ t;
					stp[12+i]  = {t[15:0], t[31:16]};
				end
				2'd1: begin
					t          = w_q[8+i] + w_q[12+i];
					stp[8+i]   = t;
					t          = w_q[4+i] ^ t;
					stp[4+i]   = {t[19:0], t[31:20]};
				end
				2'd2: begin
					t          = w_q[i] + w_q[4+i];
					stp[i]     = t;
					t          = w_q[12+i] ^ t;
					stp[12+i]  = {t[23:0], t[31:24]};
				end
				default: begin
					t          = w_q[8+i] + w_q[12+i];
					stp[8+i]   = t;
					t          = w_q[4+i] ^ t;
					stp[4+i]   = {t[24:0], t[31:25]};
				end
			endcase
		end
		rot = stp;
		if (cmd.step == STEP_LAST) begin
			for (int r = 1; r < 4; r++) begin
				for (int j = 0; j < 4; j++) begin
					if (cmd.diag)
						rot[4*r+j] = stp[4*r + ((j - r) & 3)];
					else
						rot[4*r+j] = stp[4*r + ((j + r) & 3)];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_init) begin
			w_q <= init;
		end else if (cmd.round_en) begin
			w_q <= rot;
		end else if (cmd.add_back) begin
			for (int i = 0; i < STATE_WORDS; i++)
				w_q[i] <= w_q[i] + init[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctr_q <= '0;
			pos_q <= MAX_COUNT;
		end else if (cfg_hit) begin
			ctr_q <= '0;
			pos_q <= MAX_COUNT;
		end else if (cmd.add_back) begin
			ctr_q <= ctr_q + 64'd1;
			pos_q <= '0;
		end else if (cmd.emit) begin
			pos_q <= pos_q + CNT_W'(1);
		end
	end

	assign cur_byte = w_q[pos_q[5:2]][8*pos_q[1:0] +: 8];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit || cmd.emit_err) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			key_byte_q <= cur_byte;
			last_q     <= cmd.emit_last;
			status_q   <= 1'b0;
		end else if (cmd.emit_err) begin
			key_byte_q <= '0;
			last_q     <= 1'b1;
			status_q   <= 1'b1;
		end
	end

	assign sts.buf_empty = pos_q[CNT_W-1];
	assign sts.out_ready = !out_valid_q || !out_stall;

	assign out_valid = out_valid_q;
	assign key_byte  = key_byte_q;
	assign last_byte = last_q;
	assign status    = status_q;

endmodule

// ----- rtl/cc20_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cc20_ctrl
// Request sequencer: takes a request, runs block refills and byte emission.
// ----------------------------------------------------------------------------
module cc20_ctrl
	import cc20_pkg::*;
#(
	parameter int DOUBLE_ROUNDS = 10
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [CNT_W-1:0] byte_count,
	input  cc20_sts_t        sts,
	output cc20_cmd_t        cmd
);

	localparam int RND_W = $clog2(DOUBLE_ROUNDS);
	localparam logic [RND_W-1:0] RND_LAST = RND_W'(DOUBLE_ROUNDS - 1);

	cc20_state_t      state_q, state_nxt;
	logic [1:0]       step_q;
	logic             diag_q;
	logic [RND_W-1:0] rnd_q;
	logic [CNT_W-1:0] rem_q;
	logic             rounds_done;
	logic             rem_last;

	assign rounds_done = (step_q == STEP_LAST) && diag_q && (rnd_q == RND_LAST);
	assign rem_last    = (rem_q == CNT_W'(1));

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid)
					state_nxt = (byte_count == '0) ? ST_ERR : ST_EMIT;
			end
			ST_ERR: begin
				if (sts.out_ready)
					state_nxt = ST_IDLE;
			end
			ST_EMIT: begin
				if (sts.buf_empty)
					state_nxt = ST_LOAD;
				else if (sts.out_ready && rem_last)
					state_nxt = ST_IDLE;
			end
			ST_LOAD:  state_nxt = ST_ROUND;
			ST_ROUND: begin
				if (rounds_done)
					state_nxt = ST_ADD;
			end
			ST_ADD:   state_nxt = ST_EMIT;
			default:  state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd           = '0;
		cmd.step      = step_q;
		cmd.diag      = diag_q;
		cmd.emit_last = rem_last;
		in_stall      = 1'b1;
		unique case (state_q)
			ST_IDLE:  in_stall = 1'b0;
			ST_ERR:   cmd.emit_err = sts.out_ready;
			ST_EMIT:  cmd.emit = !sts.buf_empty && sts.out_ready;
			ST_LOAD:  cmd.load_init = 1'b1;
			ST_ROUND: cmd.round_en = 1'b1;
			ST_ADD:   cmd.add_back = 1'b1;
			default:  ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
			diag_q  <= 1'b0;
			rnd_q   <= '0;
			rem_q   <= '0;
		end else begin
			state_q <= state_nxt;
			if (state_q == ST_IDLE && in_valid)
				rem_q <= (byte_count > MAX_COUNT) ? MAX_COUNT : byte_count;
			else if (cmd.emit)
				rem_q <= rem_q - CNT_W'(1);
			if (cmd.load_init) begin
				step_q <= '0;
				diag_q <= 1'b0;
				rnd_q  <= '0;
			end else if (cmd.round_en) begin
				step_q <= step_q + 2'd1;
				if (step_q == STEP_LAST) begin
					diag_q <= ~diag_q;
					if (diag_q)
						rnd_q <= rnd_q + RND_W'(1);
				end
			end
		end
	end

endmodule

// ----- rtl/chacha20_keystream_generator_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chacha20_keystream_generator_unit
// ChaCha20 keystream generator, 64-bit block counter and 64-bit nonce.
// ----------------------------------------------------------------------------
// Usage:
//   Key and nonce are written through cfg_we/cfg_index/cfg_data while idle;
//   a key or nonce write restarts the stream at counter 0, buffer empty.
//   A request transaction on in_valid/in_stall carries byte_count (1..64,
//   larger values give 64 bytes). The block answers with that many output
//   transactions, one keystream byte each, last_byte set on the final one.
//   A zero count gives a single transaction with status 1 and last_byte 1.
//   One request is in work at a time; in_stall stays high until its final
//   byte is in the output register, which frees the input side.
//   After a request is taken, bytes are emitted in the ST_EMIT state into the
//   output register at one per cycle while the output is not stalled and the
//   buffer holds bytes. Each time the 64-byte block is used up, the byte
//   stream pauses for a refill: the empty buffer is seen, the state is loaded,
//   the quarter-round steps of DOUBLE_ROUNDS double rounds run on the single
//   step unit, and the input words are added back.
//   A stall on out_stall holds the output register and pauses emission.
//   Reset clears key, nonce and counter, and leaves the buffer empty.
// ----------------------------------------------------------------------------
module chacha20_keystream_generator_unit
	import cc20_pkg::*;
#(
	parameter int DOUBLE_ROUNDS = 10
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [CNT_W-1:0]     byte_count,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [7:0]           key_byte,
	output logic                 last_byte,
	output logic                 status
);

	cc20_cmd_t cmd;
	cc20_sts_t sts;

	cc20_ctrl #(
		.DOUBLE_ROUNDS (DOUBLE_ROUNDS)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.byte_count (byte_count),
		.sts        (sts),
		.cmd        (cmd)
	);

	cc20_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.sts       (sts),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.key_byte  (key_byte),
		.last_byte (last_byte),
		.status    (status)
	);

endmodule

// ----- rtl/cc20_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cc20_checker
// Port-level checks for the ChaCha20 keystream generator.
// ----------------------------------------------------------------------------
module cc20_checker
	import cc20_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_stall,
	input logic [CNT_W-1:0]     byte_count,
	input logic                 out_valid,
	input logic                 out_stall,
	input logic [7:0]           key_byte,
	input logic                 last_byte,
	input logic                 status
);

	// stalled output transaction holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(key_byte) &&
			$stable(last_byte) && $stable(status))
		else $error("output changed while stalled");

	// one request at a time
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("request taken while busy");

	// error result is a lone, zero, final transaction
	a_err_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status |-> last_byte && key_byte == 8'd0)
		else $error("malformed error transaction");

	// zero-length request answered through ST_ERR and the output register when output was free
	a_err_resp: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && byte_count == '0 && !out_valid |->
			##2 out_valid && status)
		else $error("missing error transaction");

endmodule

bind chacha20_keystream_generator_unit cc20_checker u_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.byte_count (byte_count),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.key_byte   (key_byte),
	.last_byte  (last_byte),
	.status     (status)
);
